>>> hdl/assert_macros.svh
// Assertion macros shared by the rasterizer RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that implies a property in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`endif
`endif

>>> hdl/tcgr_pkg.sv
// Package with the types, codes and default sizes of the text cell rasterizer.
`timescale 1ns / 1ps
package tcgr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int GLYPH_COUNT_DEF   = 96;
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 192;

  // Width of the shared adder and of pixel addresses.
  localparam int ALU_W = 16;

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_DRAW = 2'd1;
  localparam logic [1:0] FUNC_FILL = 2'd2;

  // Result kinds.
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  // Printable character range; anything else draws as a space.
  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7F;

  // Number of glyph lines in the small set.
  localparam logic [2:0] LINES_SMALL = 3'd6;

  // Last line index of a cell in each mode.
  localparam logic [2:0] LAST_LINE_BIG   = 3'd7;
  localparam logic [2:0] LAST_LINE_SMALL = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic       buffer_select;
    logic [6:0] cell_column;
    logic [5:0] cell_row;
    logic [7:0] char_code;
    logic [7:0] pixel_color;
    logic [6:0] end_column;
    logic       glyph_bank;
    logic [6:0] glyph_index;
    logic [2:0] glyph_line;
    logic [7:0] glyph_bits;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        target_buffer;
    logic [15:0] pixel_address;
    logic [5:0]  pixel_mask;
    logic [8:0]  span_length;
    logic [7:0]  write_color;
    logic        last;
  } result_t;

  // One operation for the shared adder.
  typedef struct packed {
    logic             en;
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

>>> hdl/tcgr_alu.sv
// Shared registered add/subtract unit used by the rasterizer sequencer.
`timescale 1ns / 1ps
module tcgr_alu (
  input  logic                             clk,
  input  tcgr_pkg::alu_req_t               req,
  output logic [tcgr_pkg::ALU_W-1:0]       y
);

  // The result register doubles as the row address accumulator.
  always_ff @(posedge clk) begin
    if (req.en) begin
      y <= req.sub ? (req.a - req.b) : (req.a + req.b);
    end
  end

endmodule

>>> hdl/tcgr_glyph_mem.sv
// Glyph store: one write port for loads, one registered read port for draws.
`timescale 1ns / 1ps
module tcgr_glyph_mem #(
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(2*GLYPH_COUNT*8)-1:0]     waddr,
  input  logic [7:0]                             wdata,
  input  logic [$clog2(2*GLYPH_COUNT*8)-1:0]     raddr,
  output logic [7:0]                             rdata
);

  localparam int DEPTH = 2 * GLYPH_COUNT * 8;

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/text_cell_glyph_rasterizer.sv
// Top level of the text cell rasterizer: sequencer, item latch and result registers.
//
//  Channel  | Signals                           | Direction | Content
//  ---------+-----------------------------------+-----------+-------------------------
//  item     | item_valid, item_stall, item      | in        | load, draw or fill item
//  result   | result_valid, result_stall, result| out       | glyph row write or span
//  cfg      | cfg_valid, cfg_ready, cfg_data    | in        | big_mode register write
//
// A load, or a draw or fill that fails its range checks, leaves the sequencer idle. Any other
// draw or fill keeps item_stall high through six adder setup steps, one glyph store read
// per cell row (8 rows big, 6 small) and the hand-over of the final result.
// A stall on the result channel holds the row sequence until the held result moves on.
// Reset is synchronous; it returns to idle and sets big mode. The glyph store is not
// cleared and holds nothing defined until loaded. cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module text_cell_glyph_rasterizer #(
  parameter int GLYPH_COUNT   = tcgr_pkg::GLYPH_COUNT_DEF,
  parameter int SCREEN_WIDTH  = tcgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tcgr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tcgr_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int ALU_W = tcgr_pkg::ALU_W;
  localparam int GI_W  = $clog2(2 * GLYPH_COUNT);
  localparam int AW    = GI_W + 3;

  localparam logic [10:0] COLS_BIG   = 11'(SCREEN_WIDTH / 6);
  localparam logic [10:0] COLS_SMALL = 11'(SCREEN_WIDTH / 4);
  localparam logic [10:0] ROWS_BIG   = 11'(SCREEN_HEIGHT / 8);
  localparam logic [10:0] ROWS_SMALL = 11'(SCREEN_HEIGHT / 6);
  localparam logic [8:0]  GC_LIMIT   = 9'(GLYPH_COUNT);
  localparam logic [ALU_W-1:0] ROW_STEP = ALU_W'(SCREEN_WIDTH);
  localparam logic [ALU_W-1:0] GC_OFFSET = ALU_W'(GLYPH_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_PX, S_PY, S_XE, S_GLYPH, S_MUL, S_BASE, S_ROW, S_FLUSH
  } state_t;

  state_t state;

  // Configuration register.
  logic big_mode;

  // Latched item fields.
  logic        is_fill;
  logic        tgt_buf;
  logic [6:0]  col;
  logic [5:0]  row;
  logic [10:0] endc;
  logic [7:0]  color;
  logic [6:0]  glyph;

  // Setup values produced by the shared adder; prod comes from a multiply.
  logic [ALU_W-1:0] px;
  logic [ALU_W-1:0] py;
  logic [ALU_W-1:0] xe;
  logic [ALU_W-1:0] prod;
  logic [8:0]       span;
  logic [GI_W-1:0]  gbase;
  logic [2:0]       line;

  // Held result waiting to learn whether it is the final one.
  logic                  pend_valid;
  tcgr_pkg::result_t     pend;

  // Combinational helpers.
  tcgr_pkg::alu_req_t    alu_req;
  logic [ALU_W-1:0]      alu_y;
  logic                  accept;
  logic [10:0]           cols;
  logic [10:0]           rows;
  logic [2:0]            last_line;
  logic                  in_grid;
  logic [10:0]           endc_cl;
  logic [6:0]            code_glyph;
  logic                  draw_ok;
  logic                  fill_ok;
  logic                  mem_we;
  logic [GI_W-1:0]       wbase;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [7:0]            rdata;
  logic                  out_free;
  logic                  cand;
  tcgr_pkg::result_t     cand_res;
  tcgr_pkg::result_t     pend_last;
  logic                  advance;
  logic                  res_load;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Grid size of the current mode.
  assign cols      = big_mode ? COLS_BIG : COLS_SMALL;
  assign rows      = big_mode ? ROWS_BIG : ROWS_SMALL;
  assign last_line = big_mode ? tcgr_pkg::LAST_LINE_BIG : tcgr_pkg::LAST_LINE_SMALL;

  // Item checks done on the accepting edge.
  always_comb begin
    in_grid = ({4'b0, item.cell_column} < cols) && ({5'b0, item.cell_row} < rows);
    endc_cl = ({4'b0, item.end_column} > cols) ? cols : {4'b0, item.end_column};
    if (item.char_code >= tcgr_pkg::CODE_FIRST && item.char_code <= tcgr_pkg::CODE_LAST) begin
      code_glyph = 7'(item.char_code - tcgr_pkg::CODE_FIRST);
    end else begin
      code_glyph = 7'd0;
    end
    draw_ok = in_grid && ({2'b0, code_glyph} < GC_LIMIT);
    fill_ok = in_grid && (endc_cl > {4'b0, item.cell_column});
  end

  // Glyph load write port.
  always_comb begin
    wbase  = item.glyph_bank ? (GI_W'(GLYPH_COUNT) + GI_W'(item.glyph_index))
                             : GI_W'(item.glyph_index);
    waddr  = {wbase, item.glyph_line};
    mem_we = accept && (item.func == tcgr_pkg::FUNC_LOAD)
             && ({2'b0, item.glyph_index} < GC_LIMIT)
             && !(!item.glyph_bank && item.glyph_line >= tcgr_pkg::LINES_SMALL);
  end

  // Candidate result for the glyph row now on the read port.
  always_comb begin
    cand                   = is_fill || (rdata != 8'd0);
    cand_res.kind          = is_fill ? tcgr_pkg::KIND_SPAN : tcgr_pkg::KIND_GLYPH;
    cand_res.target_buffer = tgt_buf;
    cand_res.pixel_address = alu_y;
    if (is_fill) begin
      cand_res.pixel_mask = 6'd0;
    end else if (big_mode) begin
      cand_res.pixel_mask = rdata[7:2];
    end else begin
      cand_res.pixel_mask = {rdata[7:4], 2'b00};
    end
    cand_res.span_length   = is_fill ? span : 9'd0;
    cand_res.write_color   = color;
    cand_res.last          = 1'b0;
    advance   = !cand || !pend_valid || out_free;
    pend_last      = pend;
    pend_last.last = 1'b1;
    // The result register takes a transaction when the held result moves on.
    res_load  = pend_valid && out_free && ((state == S_ROW && cand) || state == S_FLUSH);
  end

  // Operand selection for the shared adder and the glyph read address.
  always_comb begin
    alu_req.en  = 1'b1;
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    raddr       = {gbase, 3'd0};
    case (state)
      S_PX: begin
        alu_req.a = ALU_W'({col, 2'b00});
        alu_req.b = big_mode ? ALU_W'({col, 1'b0}) : '0;
      end
      S_PY: begin
        alu_req.a = big_mode ? ALU_W'({row, 3'b000}) : ALU_W'({row, 2'b00});
        alu_req.b = big_mode ? '0 : ALU_W'({row, 1'b0});
      end
      S_XE: begin
        alu_req.a = ALU_W'({endc, 2'b00});
        alu_req.b = big_mode ? ALU_W'({endc, 1'b0}) : '0;
      end
      S_GLYPH: begin
        alu_req.a = big_mode ? GC_OFFSET : '0;
        alu_req.b = ALU_W'(glyph);
      end
      S_MUL: begin
        alu_req.sub = 1'b1;
        alu_req.a   = xe;
        alu_req.b   = px;
      end
      S_BASE: begin
        alu_req.a = prod;
        alu_req.b = px;
      end
      S_ROW: begin
        alu_req.en = advance;
        alu_req.a  = alu_y;
        alu_req.b  = ROW_STEP;
        raddr      = {gbase, (advance && line != last_line) ? (line + 3'd1) : line};
      end
      default: begin
        alu_req.en = 1'b0;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      big_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      big_mode <= cfg_data;
    end
  end

  // Sequencer with item latch, setup registers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_fill <= (item.func == tcgr_pkg::FUNC_FILL);
            tgt_buf <= item.buffer_select;
            col     <= item.cell_column;
            row     <= item.cell_row;
            endc    <= endc_cl;
            color   <= item.pixel_color;
            glyph   <= code_glyph;
            line    <= 3'd0;
            case (item.func)
              tcgr_pkg::FUNC_DRAW: begin
                if (draw_ok) begin
                  state <= S_PX;
                end
              end
              tcgr_pkg::FUNC_FILL: begin
                if (fill_ok) begin
                  state <= S_PX;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_PX: begin
          state <= S_PY;
        end
        S_PY: begin
          px    <= alu_y;
          state <= S_XE;
        end
        S_XE: begin
          py    <= alu_y;
          state <= S_GLYPH;
        end
        S_GLYPH: begin
          xe    <= alu_y;
          state <= S_MUL;
        end
        S_MUL: begin
          gbase <= alu_y[GI_W-1:0];
          prod  <= py * ROW_STEP;
          state <= S_BASE;
        end
        S_BASE: begin
          span  <= alu_y[8:0];
          state <= S_ROW;
        end
        S_ROW: begin
          if (advance) begin
            if (cand) begin
              pend       <= cand_res;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                result <= pend;
              end
            end
            line <= line + 3'd1;
            if (line == last_line) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            result     <= pend_last;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcgr_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .y   (alu_y)
  );

  tcgr_glyph_mem #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_glyph_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (item.glyph_bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A held result only exists while rows are walked or handed over.
  `ASSERT_IMPLY(a_pend, clk, rst, pend_valid, state == S_ROW || state == S_FLUSH, "stray pend")
  // The row counter never passes the last line of a cell.
  `ASSERT_IMPLY(a_line_range, clk, rst, state == S_ROW, line <= last_line, "line past cell")
  // A stalled result stays offered on the next cycle.
  `ASSERT_IMPLY(a_hold, clk, rst, result_valid && result_stall, ##1 result_valid, "dropped")

endmodule
